// File: design/jsu_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helper functions for the json string unescape block
// no dependencies; compiled first

package jsu_pkg;

    localparam int JSU_QUEUE_DEPTH = 2;
    localparam int PKT_BYTES       = 6;

    // result status codes
    localparam logic [2:0] ST_BYTE    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_UNTERM  = 3'd2;
    localparam logic [2:0] ST_BAD_U   = 3'd3;
    localparam logic [2:0] ST_UNK_ESC = 3'd4;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_U = 8'h75;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } utf8_seq_t;

    // everything one input byte produces
    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] bytes;
        logic [2:0]                nbytes;
        logic [2:0]                status;
    } jsu_pkt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // single-byte escapes, {valid, byte}; the \u escape is handled elsewhere
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
        utf8_seq_t s;
        s = '0;
        if (cp < 21'h80) begin
            s.b[0] = cp[7:0];
            s.len  = 3'd1;
        end
        else if (cp < 21'h800) begin
            s.b[0] = {3'b110, cp[10:6]};
            s.b[1] = {2'b10, cp[5:0]};
            s.len  = 3'd2;
        end
        else if (cp < SUPP_BASE) begin
            s.b[0] = {4'b1110, cp[15:12]};
            s.b[1] = {2'b10, cp[11:6]};
            s.b[2] = {2'b10, cp[5:0]};
            s.len  = 3'd3;
        end
        else begin
            s.b[0] = {5'b11110, cp[20:18]};
            s.b[1] = {2'b10, cp[17:12]};
            s.b[2] = {2'b10, cp[11:6]};
            s.b[3] = {2'b10, cp[5:0]};
            s.len  = 3'd4;
        end
        return s;
    endfunction

endpackage

// File: design/jsu_if.sv
`timescale 1ns / 1ps
// valid/ready stream interfaces for the text input and the decoded results
// no dependencies

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// File: design/jsu_front.sv
`timescale 1ns / 1ps
// front end: takes one text byte per transfer, runs the escape decoder state
// and pushes a packet of results; depends on jsu_pkg and jsu_if

module jsu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    jsu_in_if.sink               text,
    input  jsu_pkg::queue_stat_t qstat,
    output logic                 push,
    output jsu_pkg::jsu_pkt_t    push_pkt
);
    import jsu_pkg::*;

    typedef enum logic [5:0] {
        M_PLAIN   = 6'b000001,
        M_ESC     = 6'b000010,
        M_HEX     = 6'b000100,
        M_WAIT_BS = 6'b001000,
        M_WAIT_U  = 6'b010000,
        M_LOW     = 6'b100000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  held_reg, held_next;

    logic [4:0]  hex;
    logic [8:0]  esc;
    logic [15:0] acc_dig;
    logic        plain_go, esc_go, start_go, pair_go, emit_held;
    logic        sec_raw, sec_cp_en;
    logic [7:0]  raw_byte;
    logic [15:0] start_val;
    logic [20:0] sec_cp;
    logic [2:0]  st;
    logic [2:0]  sec_len;
    logic [2:0]  nbytes;
    utf8_seq_t   held_seq, cp_seq;
    logic        accept;

    assign text.ready = !qstat.full;
    assign accept     = text.valid && text.ready;

    assign hex      = hex_val(text.in_byte);
    assign esc      = esc_map(text.in_byte);
    assign acc_dig  = {acc_reg[11:0], hex[3:0]};
    assign held_seq = utf8_encode({5'd0, 6'b110110, held_reg});
    assign cp_seq   = utf8_encode(sec_cp);

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        held_next = held_reg;
        plain_go  = 1'b0;
        esc_go    = 1'b0;
        start_go  = 1'b0;
        pair_go   = 1'b0;
        emit_held = 1'b0;
        sec_raw   = 1'b0;
        sec_cp_en = 1'b0;
        raw_byte  = text.in_byte;
        start_val = acc_dig;
        sec_cp    = 21'd0;
        st        = ST_BYTE;

        case (mode_reg)
            M_ESC:
            begin
                esc_go = 1'b1;
            end
            M_HEX:
            begin
                if (!hex[4]) begin
                    st = ST_BAD_U;
                end
                else begin
                    acc_next = acc_dig;
                    if (cnt_reg == 2'd3) begin
                        cnt_next = 2'd0;
                        start_go = 1'b1;
                    end
                    else begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            M_WAIT_BS:
            begin
                if (text.in_byte == CH_BSLASH) begin
                    mode_next = M_WAIT_U;
                end
                else begin
                    emit_held = 1'b1;
                    plain_go  = 1'b1;
                end
            end
            M_WAIT_U:
            begin
                if (text.in_byte == CH_LOWER_U) begin
                    mode_next = M_LOW;
                    cnt_next  = 2'd0;
                    acc_next  = 16'd0;
                end
                else begin
                    emit_held = 1'b1;
                    esc_go    = 1'b1;
                end
            end
            M_LOW:
            begin
                if (!hex[4]) begin
                    st = ST_BAD_U;
                end
                else begin
                    acc_next = acc_dig;
                    if (cnt_reg == 2'd3) begin
                        cnt_next = 2'd0;
                        if (acc_dig >= SURR_LO_MIN && acc_dig <= SURR_LO_MAX) begin
                            pair_go = 1'b1;
                        end
                        else begin
                            // not a low surrogate: flush the held one, decode the new value
                            emit_held = 1'b1;
                            start_go  = 1'b1;
                        end
                    end
                    else begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                plain_go = 1'b1;
            end
        endcase

        if (plain_go) begin
            mode_next = M_PLAIN;
            if (text.in_byte == CH_QUOTE) begin
                st = ST_DONE;
            end
            else if (text.in_byte == CH_BSLASH) begin
                mode_next = M_ESC;
            end
            else begin
                sec_raw = 1'b1;
            end
        end

        if (esc_go) begin
            mode_next = M_PLAIN;
            if (text.in_byte == CH_LOWER_U) begin
                mode_next = M_HEX;
                cnt_next  = 2'd0;
                acc_next  = 16'd0;
            end
            else if (esc[8]) begin
                sec_raw  = 1'b1;
                raw_byte = esc[7:0];
            end
            else begin
                st = ST_UNK_ESC;
            end
        end

        if (start_go) begin
            if (start_val >= SURR_HI_MIN && start_val <= SURR_HI_MAX) begin
                held_next = start_val[9:0];
                mode_next = M_WAIT_BS;
            end
            else begin
                sec_cp_en = 1'b1;
                sec_cp    = {5'd0, start_val};
                mode_next = M_PLAIN;
            end
        end

        if (pair_go) begin
            sec_cp_en = 1'b1;
            sec_cp    = SUPP_BASE + {1'b0, held_reg, acc_dig[9:0]};
            mode_next = M_PLAIN;
        end

        // text ends without a closing quote
        if (st == ST_BYTE && text.end_of_text) begin
            st = (mode_next == M_HEX || mode_next == M_LOW) ? ST_BAD_U : ST_UNTERM;
        end

        if (st != ST_BYTE) begin
            mode_next = M_PLAIN;
            cnt_next  = 2'd0;
            acc_next  = 16'd0;
            held_next = 10'd0;
        end
    end

    always_comb
    begin
        sec_len = 3'd0;
        if (sec_raw) begin
            sec_len = 3'd1;
        end
        else if (sec_cp_en) begin
            sec_len = cp_seq.len;
        end
        nbytes = (emit_held ? 3'd3 : 3'd0) + sec_len;
        // an error drops whatever this byte decoded
        if (st == ST_UNTERM || st == ST_BAD_U || st == ST_UNK_ESC) begin
            nbytes = 3'd0;
        end
    end

    always_comb
    begin
        push_pkt        = '0;
        push_pkt.nbytes = nbytes;
        push_pkt.status = st;
        if (emit_held) begin
            push_pkt.bytes[0] = held_seq.b[0];
            push_pkt.bytes[1] = held_seq.b[1];
            push_pkt.bytes[2] = held_seq.b[2];
            push_pkt.bytes[3] = sec_raw ? raw_byte : cp_seq.b[0];
            push_pkt.bytes[4] = cp_seq.b[1];
            push_pkt.bytes[5] = cp_seq.b[2];
        end
        else begin
            push_pkt.bytes[0] = sec_raw ? raw_byte : cp_seq.b[0];
            push_pkt.bytes[1] = cp_seq.b[1];
            push_pkt.bytes[2] = cp_seq.b[2];
            push_pkt.bytes[3] = cp_seq.b[3];
        end
    end

    assign push = accept && (nbytes != 3'd0 || st != ST_BYTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_PLAIN;
            cnt_reg  <= 2'd0;
            acc_reg  <= 16'd0;
            held_reg <= 10'd0;
        end
        else if (accept) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            held_reg <= held_next;
        end
    end

endmodule

// File: design/jsu_queue.sv
`timescale 1ns / 1ps
// short packet queue between the decoder front end and the result serializer
// depends on jsu_pkg

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jsu_pkg::jsu_pkt_t    push_pkt,
    input  logic                 pop,
    output jsu_pkg::jsu_pkt_t    head_pkt,
    output jsu_pkg::queue_stat_t stat
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    jsu_pkt_t         slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign head_pkt   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule

// File: design/jsu_back.sv
`timescale 1ns / 1ps
// back end: walks the head packet one result per cycle, unless stalled, into
// the output register; depends on jsu_pkg and jsu_if

module jsu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jsu_pkg::jsu_pkt_t    head_pkt,
    input  jsu_pkg::queue_stat_t qstat,
    output logic                 pop,
    jsu_out_if.source            decoded
);
    import jsu_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [2:0] status_reg, status_next;
    logic       last_reg, last_next;
    logic [3:0] total;
    logic       final_res;
    logic       load;

    assign total     = {1'b0, head_pkt.nbytes} + {3'd0, head_pkt.status != ST_BYTE};
    assign final_res = ({1'b0, idx_reg} == total - 4'd1);
    assign load      = !out_valid_reg || decoded.ready;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load) begin
            out_valid_next = !qstat.empty;
            if (!qstat.empty) begin
                if (idx_reg < head_pkt.nbytes) begin
                    byte_next   = head_pkt.bytes[idx_reg];
                    status_next = ST_BYTE;
                end
                else begin
                    byte_next   = 8'd0;
                    status_next = head_pkt.status;
                end
                last_next = final_res;
                if (final_res) begin
                    pop      = 1'b1;
                    idx_next = 3'd0;
                end
                else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign decoded.valid    = out_valid_reg;
    assign decoded.out_byte = byte_reg;
    assign decoded.status   = status_reg;
    assign decoded.last     = last_reg;

endmodule

// File: design/json_string_unescape_core.sv
`timescale 1ns / 1ps
// JSON string body unescaper, top level: decoder front end, packet queue and
// result serializer; depends on jsu_pkg, jsu_if, jsu_front, jsu_queue, jsu_back
//
// usage
//   text:    one byte of the string body per transfer, after the opening quote;
//            end_of_text marks the last byte of the available text
//   decoded: one result per transfer: a decoded byte (status 0), done on the
//            closing quote, or an error code; last marks the final result of
//            the input byte that caused it
//   a byte's first result goes to a queue slot, then to the output register
//   text takes one byte per cycle while bytes decode to at most one result
//   and the receiver does not stall; a byte that expands to n results (UTF-8,
//   a flushed surrogate) waits at the queue head, the serializer emitting one
//   result a cycle unless stalled; bytes that give no result (a backslash,
//   hex digits) push nothing to the queue; after done or an error the decoder
//   restarts on the next byte; reset clears the decoder state, the queue and
//   the output valid; a stalled receiver fills the queue, then text.ready
//   drops until the serializer frees a slot

module json_string_unescape_core #(
    parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    text,
    jsu_out_if.source decoded
);
    import jsu_pkg::*;

    jsu_pkt_t    push_pkt;
    jsu_pkt_t    head_pkt;
    queue_stat_t qstat;
    logic        push;
    logic        pop;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .qstat    (qstat),
        .push     (push),
        .push_pkt (push_pkt)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .head_pkt (head_pkt),
        .stat     (qstat)
    );

    jsu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_pkt (head_pkt),
        .qstat    (qstat),
        .pop      (pop),
        .decoded  (decoded)
    );

endmodule

// File: design/jsu_checker.sv
`timescale 1ns / 1ps
// port-level checks on the decoded result stream, bound to the top level
// depends on jsu_pkg and json_string_unescape_core

module jsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [2:0] status,
    input logic       last
);
    import jsu_pkg::*;

    // done and error results always close out their input byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_BYTE |-> last)
        else $error("status result without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_BYTE |-> out_byte == 8'd0)
        else $error("status result carries a nonzero byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (decoded.valid),
    .out_ready (decoded.ready),
    .out_byte  (decoded.out_byte),
    .status    (decoded.status),
    .last      (decoded.last)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for json_string_unescape_core: random and directed string bodies,
// a scoreboard class with its own decoder predicts every decoded result
// depends on jsu_pkg, jsu_if and the design files

module tb_top;
    import jsu_pkg::*;

    localparam int RANDOM_ITEMS   = 345;
    localparam int QUIET_ITEMS    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_B     = "b";
    localparam logic [7:0] CH_F     = "f";
    localparam logic [7:0] CH_N     = "n";
    localparam logic [7:0] CH_R     = "r";
    localparam logic [7:0] CH_T     = "t";

    typedef enum logic [2:0] {
        M_PLAIN,
        M_ESC,
        M_HEX,
        M_WAIT_BS,
        M_WAIT_U,
        M_LOW
    } decode_mode_e;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } decoded_t;

    class decode_scoreboard;
        decode_mode_e mode   = M_PLAIN;
        logic [1:0]   digits = '0;
        logic [15:0]  accum  = '0;
        logic [9:0]   held   = '0;
        logic [7:0]   step_bytes[$];
        decoded_t     expected_results[$];
        int           mismatches      = 0;
        int           results_checked = 0;
        int           ends_seen[8]    = '{default: 0};

        function void add_byte(logic [7:0] b);
            step_bytes.insert(step_bytes.size(), b);
        endfunction

        function void add_result(decoded_t r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        function void put_cp(logic [20:0] cp);
            if (cp < 21'h80) begin
                add_byte(cp[7:0]);
            end
            else if (cp < 21'h800) begin
                add_byte(8'hC0 | 8'(cp[10:6]));
                add_byte(8'h80 | 8'(cp[5:0]));
            end
            else if (cp < SUPP_BASE) begin
                add_byte(8'hE0 | 8'(cp[15:12]));
                add_byte(8'h80 | 8'(cp[11:6]));
                add_byte(8'h80 | 8'(cp[5:0]));
            end
            else begin
                add_byte(8'hF0 | 8'(cp[20:18]));
                add_byte(8'h80 | 8'(cp[17:12]));
                add_byte(8'h80 | 8'(cp[11:6]));
                add_byte(8'h80 | 8'(cp[5:0]));
            end
        endfunction

        function void put_held();
            put_cp(21'(SURR_HI_MIN) + 21'(held));
        endfunction

        function void start_code(logic [15:0] cp);
            if (cp >= SURR_HI_MIN && cp <= SURR_HI_MAX) begin
                held = 10'(cp - SURR_HI_MIN);
                mode = M_WAIT_BS;
            end
            else begin
                put_cp(21'(cp));
                mode = M_PLAIN;
            end
        endfunction

        function logic [2:0] take_plain(logic [7:0] b);
            mode = M_PLAIN;
            if (b == CH_QUOTE) return ST_DONE;
            if (b == CH_BSLASH) begin
                mode = M_ESC;
                return ST_BYTE;
            end
            add_byte(b);
            return ST_BYTE;
        endfunction

        function logic [2:0] take_escape(logic [7:0] b);
            mode = M_PLAIN;
            case (b)
                CH_QUOTE, CH_BSLASH, CH_SLASH: add_byte(b);
                CH_B: add_byte(8'h08);
                CH_F: add_byte(8'h0C);
                CH_N: add_byte(8'h0A);
                CH_R: add_byte(8'h0D);
                CH_T: add_byte(8'h09);
                CH_LOWER_U:
                begin
                    mode   = M_HEX;
                    digits = '0;
                    accum  = '0;
                end
                default: return ST_UNK_ESC;
            endcase
            return ST_BYTE;
        endfunction

        // one accepted text byte: advance the decoder and queue what it yields
        function void note_text(logic [7:0] b, logic eot);
            logic [2:0] st;
            int         d;
            int         n;
            decoded_t   r;
            st = ST_BYTE;
            step_bytes.delete();
            case (mode)
                M_ESC: st = take_escape(b);
                M_HEX, M_LOW:
                begin
                    d = hex_value(b);
                    if (d < 0) begin
                        st = ST_BAD_U;
                    end
                    else begin
                        accum = {accum[11:0], d[3:0]};
                        if (digits == 2'd3) begin
                            digits = '0;
                            if (mode == M_HEX) begin
                                start_code(accum);
                            end
                            else if (accum >= SURR_LO_MIN && accum <= SURR_LO_MAX) begin
                                put_cp(SUPP_BASE + 21'({held, 10'b0}) +
                                       21'(accum - SURR_LO_MIN));
                                mode = M_PLAIN;
                            end
                            else begin
                                // low value is no low surrogate: flush the held one
                                put_held();
                                start_code(accum);
                            end
                        end
                        else begin
                            digits = digits + 2'd1;
                        end
                    end
                end
                M_WAIT_BS:
                begin
                    if (b == CH_BSLASH) begin
                        mode = M_WAIT_U;
                    end
                    else begin
                        put_held();
                        st = take_plain(b);
                    end
                end
                M_WAIT_U:
                begin
                    if (b == CH_LOWER_U) begin
                        mode   = M_LOW;
                        digits = '0;
                        accum  = '0;
                    end
                    else begin
                        put_held();
                        st = take_escape(b);
                    end
                end
                default: st = take_plain(b);
            endcase

            if (st == ST_BYTE && eot) begin
                st = (mode == M_HEX || mode == M_LOW) ? ST_BAD_U : ST_UNTERM;
            end
            // an error drops whatever bytes this step decoded
            if (st >= ST_UNTERM) step_bytes.delete();

            n = step_bytes.size() + ((st != ST_BYTE) ? 1 : 0);
            foreach (step_bytes[i]) begin
                r.out_byte = step_bytes[i];
                r.status   = ST_BYTE;
                r.last     = (i == n - 1);
                add_result(r);
            end
            if (st != ST_BYTE) begin
                r.out_byte = 8'h00;
                r.status   = st;
                r.last     = 1'b1;
                add_result(r);
                ends_seen[st]++;
                mode   = M_PLAIN;
                digits = '0;
                accum  = '0;
                held   = '0;
            end
        endfunction

        function void check_result(logic [7:0] ob, logic [2:0] st, logic lst);
            decoded_t want;
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result %0d: byte %02h status %0d last %0d",
                             results_checked, ob, st, lst);
                end
                return;
            end
            want = expected_results.pop_front();
            if (want.out_byte !== ob || want.status !== st || want.last !== lst) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at result %0d: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                             results_checked, want.out_byte, want.status, want.last,
                             ob, st, lst);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic idle_en;
    logic stall_en;
    int   bytes_sent;

    jsu_in_if  text ();
    jsu_out_if decoded ();

    decode_scoreboard sb = new();

    json_string_unescape_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text),
        .decoded (decoded)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n              = 1'b0;
        text.valid         = 1'b0;
        text.in_byte       = 8'h00;
        text.end_of_text   = 1'b0;
        idle_en            = 1'b1;
        stall_en           = 1'b1;
        bytes_sent         = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver side: random stall bursts while enabled
    initial
    begin : decoded_ready_drive
        int hold;
        hold          = 0;
        decoded.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                decoded.ready <= 1'b0;
            end
            else if (hold > 0) begin
                decoded.ready <= 1'b0;
                hold--;
            end
            else if (stall_en && $urandom_range(0, 5) == 0) begin
                decoded.ready <= 1'b0;
                hold = $urandom_range(1, 6) - 1;
            end
            else begin
                decoded.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (text.valid && text.ready) begin
                sb.note_text(text.in_byte, text.end_of_text);
            end
            if (decoded.valid && decoded.ready) begin
                sb.check_result(decoded.out_byte, decoded.status, decoded.last);
            end
        end
    end

    // ends the run when no transfer happens on either side for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((text.valid && text.ready) || (decoded.valid && decoded.ready)) begin
                quiet_cycles = 0;
            end
            else begin
                quiet_cycles++;
            end
        end
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, sb.expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            text.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        text.valid       <= 1'b1;
        text.in_byte     <= b;
        text.end_of_text <= eot;
        do @(posedge clk); while (!(text.valid && text.ready));
        bytes_sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
    endfunction

    // leading digits of v, most significant first
    task automatic send_hex_digits(input logic [15:0] v, input int count, input logic eot_last);
        for (int i = 0; i < count; i++) begin
            send_byte(hex_char(v[15 - 4 * i -: 4]), eot_last && (i == count - 1));
        end
    endtask

    task automatic send_unicode(input logic [15:0] v);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_LOWER_U, 1'b0);
        send_hex_digits(v, 4, 1'b0);
    endtask

    function automatic logic [15:0] random_code_point();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            3: return 16'($urandom_range(16'hE000, 16'hFFFF));
            4: return 16'($urandom_range(SURR_LO_MIN, SURR_LO_MAX));
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] random_high();
        return 16'($urandom_range(SURR_HI_MIN, SURR_HI_MAX));
    endfunction

    function automatic logic [7:0] random_escape_letter();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    // one random fragment of a string body, mostly well formed
    task automatic random_fragment();
        int          pick;
        int          k;
        logic [7:0]  c;
        logic [15:0] v;
        pick = $urandom_range(0, 99);
        v    = 16'($urandom_range(0, 16'hFFFF));
        if (pick < 28) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 79) == 0);
        end
        else if (pick < 42) begin
            send_byte(CH_BSLASH, 1'b0);
            send_byte(random_escape_letter(), 1'b0);
        end
        else if (pick < 56) begin
            send_unicode(random_code_point());
        end
        else if (pick < 68) begin
            send_unicode(random_high());
            send_unicode(16'($urandom_range(SURR_LO_MIN, SURR_LO_MAX)));
        end
        else if (pick < 72) begin
            // held surrogate followed by a plain byte or the closing quote
            send_unicode(random_high());
            c = $urandom_range(0, 2) == 0 ? CH_QUOTE : 8'($urandom_range(0, 255));
            if (c == CH_BSLASH) c = "a";
            send_byte(c, 1'b0);
        end
        else if (pick < 76) begin
            send_unicode(random_high());
            send_byte(CH_BSLASH, 1'b0);
            c = $urandom_range(0, 1) ? random_escape_letter() : 8'($urandom_range(0, 255));
            if (c == CH_LOWER_U) c = CH_N;
            send_byte(c, 1'b0);
        end
        else if (pick < 80) begin
            send_unicode(random_high());
            send_unicode($urandom_range(0, 1) ? random_high() : random_code_point());
        end
        else if (pick < 86) begin
            // broken hex, in a first \u or in the low half of a pair
            if ($urandom_range(0, 1)) send_unicode(random_high());
            send_byte(CH_BSLASH, 1'b0);
            send_byte(CH_LOWER_U, 1'b0);
            send_hex_digits(v, $urandom_range(0, 3), 1'b0);
            do c = 8'($urandom_range(0, 255)); while (sb.hex_value(c) >= 0);
            send_byte(c, 1'b0);
        end
        else if (pick < 90) begin
            send_byte(CH_BSLASH, 1'b0);
            do c = 8'($urandom_range(0, 255));
            while (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B ||
                   c == CH_F || c == CH_N || c == CH_R || c == CH_T || c == CH_LOWER_U);
            send_byte(c, 1'b0);
        end
        else if (pick < 95) begin
            send_byte(CH_QUOTE, 1'b0);
        end
        else begin
            // text runs out inside an escape
            if ($urandom_range(0, 1)) send_unicode(random_high());
            k = $urandom_range(0, 4);
            send_byte(CH_BSLASH, k == 0);
            if (k > 0) begin
                send_byte(CH_LOWER_U, k == 1);
                send_hex_digits(v, k - 1, 1'b1);
            end
        end
    endtask

    initial
    begin : stimulus
        int directed_count;
        int outstanding;
        @(posedge clk iff rst_n);

        send_byte("A", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_N, 1'b0);
        send_unicode(16'hD83D);
        send_unicode(16'hDE00);
        send_byte(CH_BSLASH, 1'b0);
        send_byte("x", 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_LOWER_U, 1'b0);
        send_hex_digits(16'h1200, 2, 1'b0);
        send_byte("G", 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte("z", 1'b1);
        directed_count = bytes_sent;

        while (bytes_sent < directed_count + RANDOM_ITEMS) begin
            if (bytes_sent >= directed_count + RANDOM_ITEMS - QUIET_ITEMS) begin
                idle_en  = 1'b0;
                stall_en = 1'b0;
            end
            random_fragment();
        end
        text.valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        outstanding = sb.expected_results.size();
        if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
        $display("sent %0d text bytes, checked %0d decoded results, %0d mismatches",
                 bytes_sent, sb.results_checked, sb.mismatches);
        $display("strings closed %0d, unterminated %0d, bad unicode %0d, unknown escape %0d",
                 sb.ends_seen[ST_DONE], sb.ends_seen[ST_UNTERM], sb.ends_seen[ST_BAD_U],
                 sb.ends_seen[ST_UNK_ESC]);
        if (sb.mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
design/jsu_pkg.sv
design/jsu_if.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape_core.sv
design/jsu_checker.sv
bench/tb_top.sv
